@@ design/negentropy_message_parser_macros.svh @@
// Assertion macros for the message parser
`ifndef NEGENTROPY_MESSAGE_PARSER_MACROS_SVH
`define NEGENTROPY_MESSAGE_PARSER_MACROS_SVH

// property that must hold at each clock edge outside reset
`define NMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define NMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/nmp_pkg.sv @@
// ----------------------------------------------------------------------------
// nmp_pkg
// Types and constants shared by the message parser modules.
// ----------------------------------------------------------------------------
package nmp_pkg;

    localparam int MAX_MSG_BYTES = 65536;
    localparam int OFF_W         = $clog2(MAX_MSG_BYTES + 1);

    localparam logic [7:0] VERSION_RESET = 8'd97;
    localparam logic [15:0] MAX_RANGES_RESET = 16'd1024;
    localparam logic [6:0] VARINT_DATA_MASK = 7'h7F;
    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
    localparam logic [5:0] PREFIX_MAX = 6'd32;

    typedef enum logic [0:0] {
        CFG_EXPECTED_VERSION = 1'b0,
        CFG_MAX_RANGES       = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_VERSION = 3'd1,
        ST_OVERLONG    = 3'd2,
        ST_TRUNCATED   = 3'd3,
        ST_PREFIX_BIG  = 3'd4,
        ST_BAD_MODE    = 3'd5,
        ST_TOO_MANY    = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        P_VERSION = 4'd0,
        P_TS      = 4'd1,
        P_PLEN    = 4'd2,
        P_PREFIX  = 4'd3,
        P_MODE    = 4'd4,
        P_FP      = 4'd5,
        P_COUNT   = 4'd6,
        P_IDS     = 4'd7,
        P_BFLEN   = 4'd8,
        P_BF      = 4'd9,
        P_DRAIN   = 4'd10
    } phase_t;

    localparam logic KIND_RANGE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] range_index;
        logic [63:0] timestamp;
        logic        ts_infinite;
        logic [5:0]  pfx_bytes;
        logic [1:0]  mode;
        logic [10:0] item_count;
        logic [15:0] bf_bytes;
        logic [15:0] payload_offset;
        logic [2:0]  status;
        logic        last;
    } out_item_t;

    // results of one byte, handed from the parser core to the output queue
    typedef struct packed {
        logic      desc_valid;
        out_item_t desc;
        logic      sum_valid;
        out_item_t sum;
    } step_result_t;

endpackage

@@ design/nmp_core.sv @@
// ----------------------------------------------------------------------------
// nmp_core
// Parser state and the per-byte transition; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module nmp_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  nmp_pkg::in_item_t     item,
    input  logic [7:0]            expected_version,
    input  logic [15:0]           max_ranges,
    output nmp_pkg::step_result_t result
);

    localparam int OW = nmp_pkg::OFF_W;
    localparam logic [OW-1:0] MAXB = OW'(nmp_pkg::MAX_MSG_BYTES);

    nmp_pkg::phase_t phase_reg, phase_next;
    logic [63:0] vval_reg, vval_next, prev_ts_reg, prev_ts_next, cur_ts_reg, cur_ts_next;
    logic [3:0]  vbytes_reg, vbytes_next;
    logic        cur_inf_reg, cur_inf_next;
    logic [5:0]  cur_plen_reg, cur_plen_next;
    logic [1:0]  cur_mode_reg, cur_mode_next;
    logic [10:0] cur_cnt_reg, cur_cnt_next;
    logic [15:0] cur_bfl_reg, cur_bfl_next;
    logic [16:0] skip_reg, skip_next;
    logic [15:0] ranges_reg, ranges_next;
    logic [OW-1:0] off_reg, off_next;
    logic [15:0] cur_po_reg, cur_po_next;
    logic [2:0]  err_reg, err_next;

    logic [63:0] vfed;
    logic [3:0]  vcnt;
    logic [OW-1:0] room;
    logic [16:0] skip_dec;
    logic        complete;
    logic [2:0]  sum_st;

    always_comb
    begin
        phase_next   = phase_reg;
        vval_next    = vval_reg;
        vbytes_next  = vbytes_reg;
        prev_ts_next = prev_ts_reg;
        cur_ts_next  = cur_ts_reg;
        cur_inf_next = cur_inf_reg;
        cur_plen_next = cur_plen_reg;
        cur_mode_next = cur_mode_reg;
        cur_cnt_next = cur_cnt_reg;
        cur_bfl_next = cur_bfl_reg;
        skip_next    = skip_reg;
        ranges_next  = ranges_reg;
        cur_po_next  = cur_po_reg;
        err_next     = err_reg;
        off_next     = (off_reg < MAXB) ? off_reg + 1'b1 : off_reg;
        complete     = 1'b0;
        room         = (off_reg < MAXB) ? MAXB - off_reg - 1'b1 : '0;
        vfed         = {vval_reg[56:0], item.byte_value[6:0] & nmp_pkg::VARINT_DATA_MASK};
        vcnt         = vbytes_reg + 4'd1;
        skip_dec     = (skip_reg != 17'd0) ? skip_reg - 17'd1 : skip_reg;
        result       = '0;

        if (err_reg == nmp_pkg::ST_OK && phase_reg != nmp_pkg::P_DRAIN) begin
            if (off_reg >= MAXB) begin
                err_next = nmp_pkg::ST_TRUNCATED;
                phase_next = nmp_pkg::P_DRAIN;
            end else begin
                unique case (phase_reg)
                    nmp_pkg::P_VERSION:
                    begin
                        if (item.byte_value != expected_version) begin
                            err_next = nmp_pkg::ST_BAD_VERSION;
                            phase_next = nmp_pkg::P_DRAIN;
                        end else begin
                            phase_next = nmp_pkg::P_TS;
                        end
                    end
                    nmp_pkg::P_FP, nmp_pkg::P_IDS, nmp_pkg::P_BF, nmp_pkg::P_PREFIX:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 17'd0) begin
                            if (phase_reg == nmp_pkg::P_PREFIX)
                                phase_next = nmp_pkg::P_MODE;
                            else if (phase_reg == nmp_pkg::P_IDS && cur_mode_reg == 2'd3)
                                phase_next = nmp_pkg::P_BFLEN;
                            else
                                complete = 1'b1;
                        end
                    end
                    nmp_pkg::P_TS, nmp_pkg::P_PLEN, nmp_pkg::P_MODE, nmp_pkg::P_COUNT,
                    nmp_pkg::P_BFLEN:
                    begin
                        vval_next = vfed;
                        vbytes_next = vcnt;
                        if (item.byte_value[7]) begin
                            if (vcnt >= nmp_pkg::VARINT_MAX_BYTES) begin
                                err_next = nmp_pkg::ST_OVERLONG;
                                phase_next = nmp_pkg::P_DRAIN;
                            end
                        end else begin
                            vval_next = '0;
                            vbytes_next = '0;
                            unique case (phase_reg)
                                nmp_pkg::P_TS:
                                begin
                                    if (vfed == 64'd0) begin
                                        cur_inf_next = 1'b1;
                                        cur_ts_next = '1;
                                    end else begin
                                        cur_inf_next = 1'b0;
                                        cur_ts_next = prev_ts_reg + (vfed - 64'd1);
                                        prev_ts_next = prev_ts_reg + (vfed - 64'd1);
                                    end
                                    cur_cnt_next = '0;
                                    cur_bfl_next = '0;
                                    phase_next = nmp_pkg::P_PLEN;
                                end
                                nmp_pkg::P_PLEN:
                                begin
                                    if (vfed > 64'(nmp_pkg::PREFIX_MAX)) begin
                                        err_next = nmp_pkg::ST_PREFIX_BIG;
                                        phase_next = nmp_pkg::P_DRAIN;
                                    end else begin
                                        cur_plen_next = vfed[5:0];
                                        skip_next = 17'(vfed[5:0]);
                                        phase_next = (vfed == 64'd0) ? nmp_pkg::P_MODE
                                                                     : nmp_pkg::P_PREFIX;
                                    end
                                end
                                nmp_pkg::P_MODE:
                                begin
                                    if (vfed > 64'd3) begin
                                        err_next = nmp_pkg::ST_BAD_MODE;
                                        phase_next = nmp_pkg::P_DRAIN;
                                    end else begin
                                        cur_mode_next = vfed[1:0];
                                        cur_po_next = 16'(off_reg + 1'b1);
                                        if (vfed == 64'd0) begin
                                            complete = 1'b1;
                                        end else if (vfed == 64'd1) begin
                                            skip_next = 17'd16;
                                            phase_next = nmp_pkg::P_FP;
                                        end else begin
                                            phase_next = nmp_pkg::P_COUNT;
                                        end
                                    end
                                end
                                nmp_pkg::P_COUNT:
                                begin
                                    if (vfed > 64'd2047 || vfed > 64'(room >> 5)) begin
                                        err_next = nmp_pkg::ST_TRUNCATED;
                                        phase_next = nmp_pkg::P_DRAIN;
                                    end else begin
                                        cur_cnt_next = vfed[10:0];
                                        skip_next = {1'b0, vfed[10:0], 5'd0};
                                        if (vfed != 64'd0)
                                            phase_next = nmp_pkg::P_IDS;
                                        else if (cur_mode_reg == 2'd3)
                                            phase_next = nmp_pkg::P_BFLEN;
                                        else
                                            complete = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    if (vfed > 64'd65535 || vfed > 64'(room)) begin
                                        err_next = nmp_pkg::ST_TRUNCATED;
                                        phase_next = nmp_pkg::P_DRAIN;
                                    end else begin
                                        cur_bfl_next = vfed[15:0];
                                        skip_next = {1'b0, vfed[15:0]};
                                        if (vfed != 64'd0)
                                            phase_next = nmp_pkg::P_BF;
                                        else
                                            complete = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (complete) begin
            if (ranges_reg >= max_ranges) begin
                err_next = nmp_pkg::ST_TOO_MANY;
                phase_next = nmp_pkg::P_DRAIN;
            end else begin
                result.desc_valid = 1'b1;
                result.desc.kind = nmp_pkg::KIND_RANGE;
                result.desc.range_index = ranges_reg;
                result.desc.timestamp = cur_ts_next;
                result.desc.ts_infinite = cur_inf_next;
                result.desc.pfx_bytes = cur_plen_next;
                result.desc.mode = cur_mode_next;
                result.desc.item_count = cur_cnt_next;
                result.desc.bf_bytes = cur_bfl_next;
                result.desc.payload_offset = cur_po_next;
                result.desc.status = nmp_pkg::ST_OK;
                result.desc.last = ~item.last_byte;
                ranges_next = ranges_reg + 16'd1;
                phase_next = nmp_pkg::P_TS;
            end
        end

        sum_st = err_next;
        if (sum_st == nmp_pkg::ST_OK && !(phase_next == nmp_pkg::P_TS && vbytes_next == 4'd0))
            sum_st = nmp_pkg::ST_TRUNCATED;
        result.sum = '0;
        result.sum.kind = nmp_pkg::KIND_SUMMARY;
        result.sum.range_index = ranges_next;
        result.sum.status = sum_st;
        result.sum.last = 1'b1;
        result.sum_valid = item.last_byte;
        result.desc.last = ~item.last_byte;

        if (item.last_byte) begin
            phase_next = nmp_pkg::P_VERSION;
            vval_next = '0; vbytes_next = '0; prev_ts_next = '0; cur_ts_next = '0;
            cur_inf_next = 1'b0; cur_plen_next = '0; cur_mode_next = '0;
            cur_cnt_next = '0; cur_bfl_next = '0; skip_next = '0; ranges_next = '0;
            off_next = '0; cur_po_next = '0; err_next = nmp_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= nmp_pkg::P_VERSION;
            vval_reg <= '0; vbytes_reg <= '0; prev_ts_reg <= '0; cur_ts_reg <= '0;
            cur_inf_reg <= 1'b0; cur_plen_reg <= '0; cur_mode_reg <= '0;
            cur_cnt_reg <= '0; cur_bfl_reg <= '0; skip_reg <= '0; ranges_reg <= '0;
            off_reg <= '0; cur_po_reg <= '0; err_reg <= nmp_pkg::ST_OK;
        end else if (step) begin
            phase_reg <= phase_next;
            vval_reg <= vval_next; vbytes_reg <= vbytes_next;
            prev_ts_reg <= prev_ts_next; cur_ts_reg <= cur_ts_next;
            cur_inf_reg <= cur_inf_next; cur_plen_reg <= cur_plen_next;
            cur_mode_reg <= cur_mode_next; cur_cnt_reg <= cur_cnt_next;
            cur_bfl_reg <= cur_bfl_next; skip_reg <= skip_next; ranges_reg <= ranges_next;
            off_reg <= off_next; cur_po_reg <= cur_po_next; err_reg <= err_next;
        end
    end

`include "negentropy_message_parser_macros.svh"
    `NMP_ASSERT(a_err_drain, (err_reg == nmp_pkg::ST_OK) || (phase_reg == nmp_pkg::P_DRAIN),
                "error without drain")
    // an overlong varint leaves the full count behind, but only while draining
    `NMP_ASSERT(a_vbytes, (vbytes_reg < nmp_pkg::VARINT_MAX_BYTES) ||
                (phase_reg == nmp_pkg::P_DRAIN), "varint count overflow")
    `NMP_ASSERT_NEXT(a_restart, step && item.last_byte,
                     phase_reg == nmp_pkg::P_VERSION && ranges_reg == 16'd0,
                     "no restart after last byte")

endmodule

@@ design/nmp_outq.sv @@
// ----------------------------------------------------------------------------
// nmp_outq
// Result queue: holds up to four result items between core and output port.
// ----------------------------------------------------------------------------
module nmp_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  nmp_pkg::step_result_t result,
    output logic                  room,
    output logic                  valid,
    input  logic                  stall,
    output nmp_pkg::out_item_t    data
);

    nmp_pkg::out_item_t mem_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic pop;
    logic [1:0] n_in;

    assign valid = (cnt_reg != 3'd0);
    assign data  = mem_reg[rd_reg];
    assign pop   = valid && !stall;
    assign room  = (cnt_reg <= 3'd2);
    assign n_in  = push ? (2'(result.desc_valid) + 2'(result.sum_valid)) : 2'd0;
    assign cnt_next = cnt_reg + 3'(n_in) - 3'(pop);

    always_ff @(posedge clk)
    begin
        if (push && result.desc_valid)
            mem_reg[wr_reg] <= result.desc;
        if (push && result.sum_valid)
            mem_reg[result.desc_valid ? wr_reg + 2'd1 : wr_reg] <= result.sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_reg + n_in;
            rd_reg <= rd_reg + 2'(pop);
            cnt_reg <= cnt_next;
        end
    end

`include "negentropy_message_parser_macros.svh"
    `NMP_ASSERT(a_no_overflow, cnt_reg <= 3'd4, "queue overflow")
    `NMP_ASSERT_NEXT(a_push_room, push && (result.desc_valid || result.sum_valid),
                     cnt_reg != 3'd0, "push lost")

endmodule

@@ design/negentropy_message_parser.sv @@
// ----------------------------------------------------------------------------
// negentropy_message_parser
// Byte-serial parser for set-reconciliation messages.
// ----------------------------------------------------------------------------
// One message byte is accepted per cycle, back to back; each byte is decoded in
// combinational logic by the parser core and its results, if any (a range
// descriptor and, on the last byte, a summary) go into a four-entry result
// queue. Input stalls only while the queue holds more than two results, so a
// sustained rate of one byte per cycle holds whenever the output is not stalled.
module negentropy_message_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nmp_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output nmp_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    logic [7:0]  version_reg;
    logic [15:0] max_ranges_reg;
    logic        room, step;
    nmp_pkg::step_result_t result;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room;
    assign step      = in_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            version_reg <= nmp_pkg::VERSION_RESET;
            max_ranges_reg <= nmp_pkg::MAX_RANGES_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                nmp_pkg::CFG_EXPECTED_VERSION: version_reg <= cfg_data[7:0];
                nmp_pkg::CFG_MAX_RANGES:       max_ranges_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    nmp_core u_core (
        .clk(clk), .rst_n(rst_n), .step(step), .item(in_data),
        .expected_version(version_reg), .max_ranges(max_ranges_reg), .result(result)
    );

    nmp_outq u_outq (
        .clk(clk), .rst_n(rst_n), .push(step), .result(result), .room(room),
        .valid(out_valid), .stall(out_stall), .data(out_data)
    );

endmodule

@@ bench/negentropy_message_parser_checker.sv @@
// ----------------------------------------------------------------------------
// negentropy_message_parser_checker
// Watches the byte and result channels of the message parser, decodes each
// accepted byte with its own parser state and compares every result against
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module negentropy_message_parser_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  nmp_pkg::in_item_t   in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  nmp_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output int                  fail_count,
    output int                  pending_results,
    output int                  ranges_checked,
    output int                  summaries_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // configuration copy
    logic [7:0]  version_reg;
    logic [15:0] range_limit;

    // parser state copy
    nmp_pkg::phase_t  ph;
    logic [63:0]      vacc;
    int unsigned      vcount;
    logic [63:0]      prev_ts;
    logic [63:0]      cur_ts;
    logic             cur_inf;
    logic [5:0]       cur_plen;
    logic [1:0]       cur_md;
    logic [10:0]      cur_cnt;
    logic [15:0]      cur_bflen;
    int unsigned      skip_left;
    int unsigned      range_count;
    int unsigned      offset;
    int unsigned      cur_poff;
    nmp_pkg::status_t err;

    nmp_pkg::out_item_t expected_results[$];

    task automatic clear_message();
        ph = nmp_pkg::P_VERSION;
        vacc = '0;
        vcount = 0;
        prev_ts = '0;
        cur_ts = '0;
        cur_inf = 1'b0;
        cur_plen = '0;
        cur_md = '0;
        cur_cnt = '0;
        cur_bflen = '0;
        skip_left = 0;
        range_count = 0;
        offset = 0;
        cur_poff = 0;
        err = nmp_pkg::ST_OK;
    endtask

    task automatic abort_message(nmp_pkg::status_t code);
        err = code;
        ph = nmp_pkg::P_DRAIN;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // decode one byte; pushes the results it causes
    task automatic decode_byte(nmp_pkg::in_item_t it);
        int unsigned        off;
        int unsigned        room;
        int unsigned        max_bytes;
        logic               complete;
        logic               done;
        logic               overlong;
        logic [63:0]        v;
        nmp_pkg::out_item_t r;
        nmp_pkg::status_t   st;
        max_bytes = 32'(nmp_pkg::MAX_MSG_BYTES);
        off = offset;
        complete = 1'b0;
        done = 1'b0;
        overlong = 1'b0;
        v = '0;
        if (offset < max_bytes)
            offset++;
        if (err == nmp_pkg::ST_OK && ph != nmp_pkg::P_DRAIN) begin
            room = (off < max_bytes) ? max_bytes - off - 32'd1 : 32'd0;
            if (off >= max_bytes) begin
                abort_message(nmp_pkg::ST_TRUNCATED);
            end
            else if (ph == nmp_pkg::P_VERSION) begin
                if (it.byte_value != version_reg)
                    abort_message(nmp_pkg::ST_BAD_VERSION);
                else
                    ph = nmp_pkg::P_TS;
            end
            else if (ph == nmp_pkg::P_FP || ph == nmp_pkg::P_IDS || ph == nmp_pkg::P_BF ||
                     ph == nmp_pkg::P_PREFIX) begin
                if (skip_left > 0)
                    skip_left--;
                if (skip_left == 0) begin
                    if (ph == nmp_pkg::P_PREFIX)
                        ph = nmp_pkg::P_MODE;
                    else if (ph == nmp_pkg::P_IDS && cur_md == 2'd3)
                        ph = nmp_pkg::P_BFLEN;
                    else
                        complete = 1'b1;
                end
            end
            else begin
                vacc = {vacc[56:0], it.byte_value[6:0]};
                vcount++;
                if (it.byte_value[7]) begin
                    if (vcount >= 10)
                        overlong = 1'b1;
                end
                else begin
                    v = vacc;
                    vacc = '0;
                    vcount = 0;
                    done = 1'b1;
                end
                if (overlong) begin
                    abort_message(nmp_pkg::ST_OVERLONG);
                end
                else if (done) begin
                    case (ph)
                        nmp_pkg::P_TS: begin
                            if (v == 64'd0) begin
                                cur_inf = 1'b1;
                                cur_ts = '1;
                            end
                            else begin
                                cur_inf = 1'b0;
                                cur_ts = prev_ts + (v - 64'd1);
                                prev_ts = cur_ts;
                            end
                            cur_cnt = '0;
                            cur_bflen = '0;
                            ph = nmp_pkg::P_PLEN;
                        end
                        nmp_pkg::P_PLEN: begin
                            if (v > 64'd32) begin
                                abort_message(nmp_pkg::ST_PREFIX_BIG);
                            end
                            else begin
                                cur_plen = v[5:0];
                                skip_left = 32'(v[5:0]);
                                ph = (v == 64'd0) ? nmp_pkg::P_MODE : nmp_pkg::P_PREFIX;
                            end
                        end
                        nmp_pkg::P_MODE: begin
                            if (v > 64'd3) begin
                                abort_message(nmp_pkg::ST_BAD_MODE);
                            end
                            else begin
                                cur_md = v[1:0];
                                cur_poff = off + 32'd1;
                                if (v == 64'd0) begin
                                    complete = 1'b1;
                                end
                                else if (v == 64'd1) begin
                                    skip_left = 16;
                                    ph = nmp_pkg::P_FP;
                                end
                                else begin
                                    ph = nmp_pkg::P_COUNT;
                                end
                            end
                        end
                        nmp_pkg::P_COUNT: begin
                            if (v > 64'd2047 || v > 64'(room / 32)) begin
                                abort_message(nmp_pkg::ST_TRUNCATED);
                            end
                            else begin
                                cur_cnt = v[10:0];
                                skip_left = 32'(v[10:0]) * 32'd32;
                                if (skip_left != 0)
                                    ph = nmp_pkg::P_IDS;
                                else if (cur_md == 2'd3)
                                    ph = nmp_pkg::P_BFLEN;
                                else
                                    complete = 1'b1;
                            end
                        end
                        default: begin
                            if (v > 64'd65535 || v > 64'(room)) begin
                                abort_message(nmp_pkg::ST_TRUNCATED);
                            end
                            else begin
                                cur_bflen = v[15:0];
                                skip_left = 32'(v[15:0]);
                                if (v != 64'd0)
                                    ph = nmp_pkg::P_BF;
                                else
                                    complete = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
        if (complete) begin
            if (range_count >= 32'(range_limit)) begin
                abort_message(nmp_pkg::ST_TOO_MANY);
            end
            else begin
                r = '0;
                r.kind = nmp_pkg::KIND_RANGE;
                r.range_index = 16'(range_count);
                r.timestamp = cur_ts;
                r.ts_infinite = cur_inf;
                r.pfx_bytes = cur_plen;
                r.mode = cur_md;
                r.item_count = cur_cnt;
                r.bf_bytes = cur_bflen;
                r.payload_offset = 16'(cur_poff);
                r.status = nmp_pkg::ST_OK;
                r.last = ~it.last_byte;
                expected_results.push_back(r);
                range_count++;
                ph = nmp_pkg::P_TS;
            end
        end
        if (it.last_byte) begin
            st = err;
            if (st == nmp_pkg::ST_OK && !(ph == nmp_pkg::P_TS && vcount == 0))
                st = nmp_pkg::ST_TRUNCATED;
            r = '0;
            r.kind = nmp_pkg::KIND_SUMMARY;
            r.range_index = 16'(range_count);
            r.status = st;
            r.last = 1'b1;
            expected_results.push_back(r);
            clear_message();
        end
    endtask

    task automatic compare_result(nmp_pkg::out_item_t got);
        nmp_pkg::out_item_t w;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(got.range_index), 64'd0);
            return;
        end
        w = expected_results.pop_front();
        if (got.kind != w.kind) report_mismatch("kind", 64'(got.kind), 64'(w.kind));
        if (got.range_index != w.range_index)
            report_mismatch("range_index", 64'(got.range_index), 64'(w.range_index));
        if (got.timestamp != w.timestamp)
            report_mismatch("timestamp", got.timestamp, w.timestamp);
        if (got.ts_infinite != w.ts_infinite)
            report_mismatch("ts_infinite", 64'(got.ts_infinite), 64'(w.ts_infinite));
        if (got.pfx_bytes != w.pfx_bytes)
            report_mismatch("pfx_bytes", 64'(got.pfx_bytes), 64'(w.pfx_bytes));
        if (got.mode != w.mode) report_mismatch("mode", 64'(got.mode), 64'(w.mode));
        if (got.item_count != w.item_count)
            report_mismatch("item_count", 64'(got.item_count), 64'(w.item_count));
        if (got.bf_bytes != w.bf_bytes)
            report_mismatch("bf_bytes", 64'(got.bf_bytes), 64'(w.bf_bytes));
        if (got.payload_offset != w.payload_offset)
            report_mismatch("payload_offset", 64'(got.payload_offset),
                            64'(w.payload_offset));
        if (got.status != w.status)
            report_mismatch("status", 64'(got.status), 64'(w.status));
        if (got.last != w.last) report_mismatch("last", 64'(got.last), 64'(w.last));
        if (w.kind == nmp_pkg::KIND_SUMMARY)
            summaries_checked++;
        else
            ranges_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            version_reg = nmp_pkg::VERSION_RESET;
            range_limit = nmp_pkg::MAX_RANGES_RESET;
            clear_message();
            expected_results.delete();
            fail_count = 0;
            ranges_checked = 0;
            summaries_checked = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == nmp_pkg::CFG_EXPECTED_VERSION)
                    version_reg = cfg_data[7:0];
                else
                    range_limit = cfg_data;
            end
            if (in_valid && !in_stall)
                decode_byte(in_data);
            if (out_valid && !out_stall)
                compare_result(out_data);
        end
        pending_results = expected_results.size();
    end

endmodule

@@ bench/tb_negentropy_message_parser.sv @@
// ----------------------------------------------------------------------------
// tb_negentropy_message_parser
// Drives directed and random messages (well-formed ones with random content,
// broken ones and noise) through the parser under several idling phases and
// register settings; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_negentropy_message_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    nmp_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    nmp_pkg::out_item_t out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [0:0]         cfg_index;
    logic [15:0]        cfg_data;

    int fail_count;
    int pending_results;
    int ranges_checked;
    int summaries_checked;
    int cycle_count = 0;
    int bytes_sent;
    int send_idle_pct;
    int stall_pct;
    logic [7:0] cur_version;

    // bytes of the message being built
    logic [7:0] msg_q[$];

    negentropy_message_parser dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    negentropy_message_parser_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_results(pending_results),
        .ranges_checked(ranges_checked), .summaries_checked(summaries_checked)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall, changed at the falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(logic [7:0] b, logic lb);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data.byte_value <= b;
        in_data.last_byte <= lb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // sends the built message, marking its final byte
    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++)
            send_byte(msg_q[i], i == msg_q.size() - 1);
        msg_q.delete();
    endtask

    // MSB-first varint, optionally padded with redundant leading 0x80 bytes
    task automatic put_varint(logic [63:0] v, int pad);
        logic [6:0] grp[$];
        logic [63:0] t;
        t = v;
        do begin
            grp.push_front(t[6:0]);
            t = t >> 7;
        end while (t != 0);
        repeat (pad) msg_q.push_back(8'h80);
        for (int i = 0; i < grp.size(); i++)
            msg_q.push_back({(i != grp.size() - 1), grp[i]});
    endtask

    task automatic put_skip(int n);
        repeat (n) msg_q.push_back(8'($urandom));
    endtask

    task automatic put_range(int md, int plen, int cnt, int bflen);
        logic [63:0] tsv;
        int pad;
        case ($urandom_range(3))
            0: tsv = 64'd0;
            1: tsv = {$urandom, $urandom};
            default: tsv = 64'($urandom_range(1000));
        endcase
        pad = ($urandom_range(9) == 0) ? 1 : 0;
        put_varint(tsv, pad);
        put_varint(64'(plen), 0);
        put_skip(plen);
        put_varint(64'(md), 0);
        if (md == 1)
            put_skip(16);
        if (md >= 2) begin
            put_varint(64'(cnt), 0);
            put_skip(cnt * 32);
        end
        if (md == 3) begin
            put_varint(64'(bflen), 0);
            put_skip(bflen);
        end
    endtask

    task automatic random_message();
        int nr;
        nr = $urandom_range(2);
        msg_q.push_back(($urandom_range(19) == 0) ? 8'($urandom) : cur_version);
        for (int i = 0; i < nr; i++) begin
            case ($urandom_range(19))
                0: put_varint(64'($urandom_range(200)), 0);   // junk, maybe bad field
                1: put_skip($urandom_range(3));               // noise
                default: put_range($urandom_range(3),
                                   ($urandom_range(7) == 0) ? 32 : $urandom_range(8),
                                   $urandom_range(2), $urandom_range(20));
            endcase
        end
        // now and then a stray byte so the message ends inside a field
        if ($urandom_range(3) == 0)
            msg_q.push_back(8'($urandom));
        send_message();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(nmp_pkg::cfg_index_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == nmp_pkg::CFG_EXPECTED_VERSION)
            cur_version = val[7:0];
    endtask

    task automatic directed_part();
        msg_q.push_back(cur_version);                   // version only
        send_message();
        msg_q.push_back(8'd96); msg_q.push_back(8'hFF); // bad version
        send_message();
        msg_q.push_back(cur_version);                   // clean ranges of every mode
        put_range(0, 0, 0, 0);
        put_range(1, 32, 0, 0);
        put_range(2, 1, 1, 0);
        put_range(3, 0, 0, 0);
        put_range(3, 2, 1, 5);
        send_message();
        msg_q.push_back(cur_version);                   // ten-byte varint still fits
        put_varint(64'd1, 9); put_varint(64'd0, 0); put_varint(64'd0, 0);
        send_message();
        msg_q.push_back(cur_version);                   // ends inside a range
        put_range(2, 0, 0, 0);
        msg_q.push_back(8'h00);
        send_message();
        msg_q.push_back(cur_version);                   // overlong varint
        repeat (10) msg_q.push_back(8'hFF);
        msg_q.push_back(8'h7F);
        send_message();
        msg_q.push_back(cur_version);                   // prefix too long
        put_varint(64'd5, 0); put_varint(64'd33, 0); msg_q.push_back(8'h00);
        send_message();
        msg_q.push_back(cur_version);                   // bad mode
        put_varint(64'd5, 0); put_varint(64'd0, 0); put_varint(64'd4, 0);
        msg_q.push_back(8'h00);
        send_message();
        msg_q.push_back(cur_version);                   // id count too big
        put_varint(64'd5, 0); put_varint(64'd0, 0); put_varint(64'd2, 0);
        put_varint(64'd2048, 0); msg_q.push_back(8'h00);
        send_message();
        msg_q.push_back(cur_version);                   // bitfield too long
        put_varint(64'd5, 0); put_varint(64'd0, 0); put_varint(64'd3, 0);
        put_varint(64'd0, 0); put_varint(64'd65536, 0); msg_q.push_back(8'h00);
        send_message();
    endtask

    initial
    begin
        bytes_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        cur_version = nmp_pkg::VERSION_RESET;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = nmp_pkg::CFG_EXPECTED_VERSION;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        directed_part();
        wait_idle();
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            case (p)
                1: write_reg(nmp_pkg::CFG_EXPECTED_VERSION, 16'd0);
                2: write_reg(nmp_pkg::CFG_MAX_RANGES, 16'd1);
                3: write_reg(nmp_pkg::CFG_EXPECTED_VERSION, 16'd255);
                4: write_reg(nmp_pkg::CFG_MAX_RANGES, 16'd65535);
                5: write_reg(nmp_pkg::CFG_MAX_RANGES, 16'd2);
                6: write_reg(nmp_pkg::CFG_EXPECTED_VERSION, 16'($urandom_range(255)));
                default: ;
            endcase
            for (int m = 0; m < 2; m++)
                random_message();
            send_idle_pct = 0;
            stall_pct = 0;
            wait_idle();
        end
        // top up with a few more messages if the byte budget is not yet met
        while (bytes_sent < 700) begin
            stall_pct = $urandom_range(1) ? 81 : 0;
            random_message();
        end
        stall_pct = 0;
        wait_idle();
        $display("sent %0d bytes; checked %0d range descriptors and %0d summaries",
                 bytes_sent, ranges_checked, summaries_checked);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/nmp_pkg.sv
design/nmp_core.sv
design/nmp_outq.sv
design/negentropy_message_parser.sv
bench/negentropy_message_parser_checker.sv
bench/tb_negentropy_message_parser.sv
